@@ rtl/bitmap_page_allocator_refcount_core_defines.svh @@
// Assertion macros for the page allocator core.
`ifndef BITMAP_PAGE_ALLOCATOR_REFCOUNT_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_REFCOUNT_CORE_DEFINES_SVH
`ifndef SYNTH
`define BPA_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("page allocator check failed");
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page allocator sequence check failed");
`else
`define BPA_ASSERT(lbl, cond)
`define BPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and defaults of the page allocator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bpa_pkg;
	localparam int DEF_NUM_PAGES = 32768;
	localparam int DEF_REF_WIDTH = 32;
	localparam int DEF_MAX_RUN   = 16;
	localparam int DEF_MAX_ALIGN = 64;

	localparam logic [15:0] RST_TOTAL_PAGES = 16'd32768;
	localparam logic [15:0] RST_FIRST_ALLOC = 16'd0;

	// register select on paddr[2]
	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_FIRST = 1'b1;

	localparam logic [2:0] CMD_ALLOC     = 3'd0;
	localparam logic [2:0] CMD_FREE      = 3'd1;
	localparam logic [2:0] CMD_INCREF    = 3'd2;
	localparam logic [2:0] CMD_DECREF    = 3'd3;
	localparam logic [2:0] CMD_QUERY     = 3'd4;
	localparam logic [2:0] CMD_MARK_FREE = 3'd5;
	localparam logic [2:0] CMD_MARK_USED = 3'd6;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_IGNORED = 3'd1;
	localparam logic [2:0] STS_BADARG  = 3'd2;
	localparam logic [2:0] STS_NOMEM   = 3'd3;
	localparam logic [2:0] STS_DEMOTED = 3'd4;
	localparam logic [2:0] STS_SATUR   = 3'd5;
	localparam logic [2:0] STS_PINNED  = 3'd6;

	typedef struct packed {
		logic [15:0] page_limit;
		logic [15:0] first_alloc_page;
	} cfg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHK,
		S_EVAL,
		S_WR,
		S_RMW,
		S_DONE
	} state_t;
endpackage

@@ rtl/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bpa_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

@@ rtl/bpa_cfg.sv @@
// ----------------------------------------------------------------------------
// bpa_cfg
// APB register file: managed page count and first allocatable page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bpa_cfg import bpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t cfg_q;
	logic wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.page_limit       <= RST_TOTAL_PAGES;
			cfg_q.first_alloc_page <= RST_FIRST_ALLOC;
		end else if (wr_en) begin
			case (paddr[2])
				REG_TOTAL: cfg_q.page_limit       <= pwdata[15:0];
				REG_FIRST: cfg_q.first_alloc_page <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TOTAL: prdata = {16'd0, cfg_q.page_limit};
			REG_FIRST: prdata = {16'd0, cfg_q.first_alloc_page};
			default:   prdata = 32'd0;
		endcase
	end
endmodule

@@ rtl/bitmap_page_allocator_refcount_core.sv @@
// Single-page commands: after accept the entry is read, modified and written back in S_RMW,
// and the result is loaded into the output registers in S_DONE; the next item is taken only back in S_IDLE.
// Alloc: the first-fit scan reads each page of a candidate run in S_CHK and checks it in S_EVAL,
// then S_WR writes the run_length pages of the run; the single RAM port serialises these accesses.
// Reset: a clearing pass over all NUM_PAGES entries marks every page used with count zero;
// no item is accepted until it ends. Config writes are taken throughout.
// ----------------------------------------------------------------------------
// bitmap_page_allocator_refcount_core
// Page frame allocator with a used bit and saturating refcount per page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_page_allocator_refcount_core_defines.svh"
module bitmap_page_allocator_refcount_core import bpa_pkg::*; #(
	parameter int NUM_PAGES = DEF_NUM_PAGES,
	parameter int REF_WIDTH = DEF_REF_WIDTH,
	parameter int MAX_RUN   = DEF_MAX_RUN,
	parameter int MAX_ALIGN = DEF_MAX_ALIGN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [15:0] page,
	input  logic [4:0]  run_length,
	input  logic [6:0]  align_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [14:0] alloc_page,
	output logic [31:0] ref_value,
	output logic [15:0] used_pages,
	output logic [15:0] free_pages
);
	localparam int AW = $clog2(NUM_PAGES);
	localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;
	localparam int EW = REF_WIDTH + 1;
	localparam logic [REF_WIDTH-1:0] PIN = {REF_WIDTH{1'b1}};
	localparam logic [REF_WIDTH-1:0] ONE = REF_WIDTH'(1);

	cfg_t cfg;
	state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	logic [2:0] cmd_q;
	logic [AW-1:0] pg_q;
	logic [4:0] cnt_q, k_q;
	logic [6:0] al_q;
	logic [CW-1:0] p_q;
	logic [15:0] free_q;
	logic [2:0] res_sts_q;
	logic [14:0] res_alloc_q;
	logic [REF_WIDTH-1:0] res_ref_q;
	logic out_valid_q;
	logic [2:0] out_sts_q;
	logic [14:0] out_alloc_q;
	logic [31:0] out_ref_q;
	logic [15:0] out_used_q, out_free_q;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic [CW-1:0] total_eff, first_al;
	logic in_acc, out_free, in_range, bad_arg, fits, rd_used, last_k;
	logic [REF_WIDTH-1:0] rd_cnt;

	logic rmw_we, rmw_finc, rmw_fdec;
	logic [EW-1:0] rmw_wdata;
	logic [2:0] rmw_sts;
	logic [REF_WIDTH-1:0] rmw_ref;

	bpa_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// entry layout: {used, count}
	bpa_ram #(.WIDTH(EW), .DEPTH(NUM_PAGES)) u_ram (
		.clk(clk), .we(ram_we), .re(ram_re), .addr(ram_addr),
		.wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign total_eff = (CW'(cfg.page_limit) < CW'(NUM_PAGES)) ?
		CW'(cfg.page_limit) : CW'(NUM_PAGES);
	assign first_al = (CW'(cfg.first_alloc_page) + CW'(align_size) - CW'(1)) &
		~(CW'(align_size) - CW'(1));
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign in_range = CW'(page) < total_eff;
	assign bad_arg  = (run_length == 5'd0) || (int'(run_length) > MAX_RUN) ||
		(align_size == 7'd0) || ((align_size & (align_size - 7'd1)) != 7'd0) ||
		(int'(align_size) > MAX_ALIGN);
	assign fits     = ((CW + 1)'(p_q) + (CW + 1)'(cnt_q)) <= (CW + 1)'(total_eff);
	assign rd_used  = ram_rdata[EW-1];
	assign rd_cnt   = ram_rdata[REF_WIDTH-1:0];
	assign last_k   = (k_q + 5'd1) == cnt_q;

	// single-page read-modify-write
	always_comb begin
		rmw_we    = 1'b0;
		rmw_finc  = 1'b0;
		rmw_fdec  = 1'b0;
		rmw_wdata = ram_rdata;
		rmw_sts   = STS_IGNORED;
		rmw_ref   = '0;
		case (cmd_q)
			CMD_FREE: begin
				if (!rd_used) begin
					rmw_sts = STS_IGNORED;
				end else if (rd_cnt == PIN) begin
					rmw_sts = STS_PINNED;
					rmw_ref = rd_cnt;
				end else if (rd_cnt > ONE) begin
					rmw_we    = 1'b1;
					rmw_wdata = {1'b1, rd_cnt - ONE};
					rmw_sts   = STS_DEMOTED;
					rmw_ref   = rd_cnt - ONE;
				end else begin
					rmw_we    = 1'b1;
					rmw_wdata = '0;
					rmw_finc  = 1'b1;
					rmw_sts   = STS_OK;
				end
			end
			CMD_INCREF: begin
				if (rd_cnt == PIN) begin
					rmw_sts = STS_PINNED;
					rmw_ref = rd_cnt;
				end else begin
					rmw_we    = 1'b1;
					rmw_wdata = {rd_used, rd_cnt + ONE};
					rmw_sts   = ((rd_cnt + ONE) == PIN) ? STS_SATUR : STS_OK;
					rmw_ref   = rd_cnt + ONE;
				end
			end
			CMD_DECREF: begin
				if (rd_cnt == '0) begin
					rmw_sts = STS_IGNORED;
				end else if (rd_cnt == PIN) begin
					rmw_sts = STS_PINNED;
					rmw_ref = rd_cnt;
				end else begin
					rmw_we    = 1'b1;
					// reaching zero releases the page
					rmw_wdata = {rd_used && (rd_cnt != ONE), rd_cnt - ONE};
					rmw_finc  = rd_used && (rd_cnt == ONE);
					rmw_sts   = STS_OK;
					rmw_ref   = rd_cnt - ONE;
				end
			end
			CMD_QUERY: begin
				rmw_sts = STS_OK;
				rmw_ref = rd_cnt;
			end
			CMD_MARK_FREE: begin
				if (rd_used) begin
					rmw_we    = 1'b1;
					rmw_wdata = '0;
					rmw_finc  = 1'b1;
					rmw_sts   = STS_OK;
				end
			end
			CMD_MARK_USED: begin
				if (!rd_used) begin
					rmw_we    = 1'b1;
					rmw_wdata = {1'b1, rd_cnt};
					rmw_fdec  = 1'b1;
					rmw_sts   = STS_OK;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == AW'(NUM_PAGES - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (in_acc) begin
					if (command == CMD_ALLOC) begin
						state_d = bad_arg ? S_DONE : S_CHK;
					end else if (in_range && command != 3'd7) begin
						state_d = S_RMW;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_CHK:  state_d = fits ? S_EVAL : S_DONE;
			S_EVAL: begin
				if (rd_used) begin
					state_d = S_CHK;
				end else if (last_k) begin
					state_d = S_WR;
				end else begin
					state_d = S_CHK;
				end
			end
			S_WR:   if (last_k) state_d = S_DONE;
			S_RMW:  state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = pg_q;
		ram_wdata = rmw_wdata;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = {1'b1, {REF_WIDTH{1'b0}}};
			end
			S_IDLE: begin
				ram_re   = 1'b1;
				ram_addr = page[AW-1:0];
			end
			S_CHK: begin
				ram_re   = fits;
				ram_addr = AW'(p_q + CW'(k_q));
			end
			S_WR: begin
				ram_we    = 1'b1;
				ram_addr  = AW'(p_q + CW'(k_q));
				ram_wdata = {1'b1, ONE};
			end
			S_RMW: ram_we = rmw_we;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cmd_q       <= CMD_ALLOC;
			pg_q        <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			al_q        <= '0;
			p_q         <= '0;
			free_q      <= '0;
			res_sts_q   <= STS_OK;
			res_alloc_q <= '0;
			res_ref_q   <= '0;
			out_valid_q <= 1'b0;
			out_sts_q   <= STS_OK;
			out_alloc_q <= '0;
			out_ref_q   <= '0;
			out_used_q  <= '0;
			out_free_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + AW'(1);
				S_IDLE: begin
					if (in_acc) begin
						cmd_q       <= command;
						pg_q        <= page[AW-1:0];
						cnt_q       <= run_length;
						al_q        <= align_size;
						p_q         <= first_al;
						k_q         <= '0;
						res_alloc_q <= '0;
						res_ref_q   <= '0;
						res_sts_q   <= (command == CMD_ALLOC && bad_arg) ? STS_BADARG :
							STS_IGNORED;
					end
				end
				S_CHK: if (!fits) res_sts_q <= STS_NOMEM;
				S_EVAL: begin
					if (rd_used) begin
						p_q <= p_q + CW'(al_q);
						k_q <= '0;
					end else if (last_k) begin
						k_q <= '0;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				S_WR: begin
					k_q <= k_q + 5'd1;
					if (free_q != 16'd0) free_q <= free_q - 16'd1;
					if (last_k) begin
						res_sts_q   <= STS_OK;
						res_alloc_q <= p_q[14:0];
					end
				end
				S_RMW: begin
					res_sts_q <= rmw_sts;
					res_ref_q <= rmw_ref;
					if (rmw_finc && free_q != 16'hFFFF) free_q <= free_q + 16'd1;
					if (rmw_fdec && free_q != 16'd0) free_q <= free_q - 16'd1;
				end
				default: ;
			endcase
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				out_sts_q   <= res_sts_q;
				out_alloc_q <= res_alloc_q;
				out_ref_q   <= 32'(res_ref_q);
				out_free_q  <= free_q;
				out_used_q  <= (total_eff > CW'(free_q)) ? 16'(total_eff - CW'(free_q)) :
					16'd0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_sts_q;
	assign alloc_page = out_alloc_q;
	assign ref_value  = out_ref_q;
	assign used_pages = out_used_q;
	assign free_pages = out_free_q;

	`BPA_ASSERT(a_we_states, !ram_we || state_q == S_CLEAR || state_q == S_WR || state_q == S_RMW)
	`BPA_ASSERT(a_clear_stalls, state_q != S_CLEAR || in_stall)
	`BPA_ASSERT(a_grant_word, state_q != S_WR || ram_wdata == {1'b1, ONE})
	`BPA_ASSERT_NEXT(a_done_holds, state_q == S_DONE && !out_free, state_q == S_DONE)
endmodule

@@ dv/tb_bitmap_page_allocator_refcount_core.sv @@
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_refcount_core
// Drives allocator commands with random idling on both sides, predicts every
// result from a local copy of the bitmap, the counts and the registers, and
// checks each result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_bitmap_page_allocator_refcount_core;
	import bpa_pkg::*;

	localparam int NPG = 32768;
	localparam logic [31:0] PINNED = 32'hFFFF_FFFF;

	typedef struct {
		logic [2:0]  cmd;
		logic [15:0] pg;
		logic [4:0]  len;
		logic [6:0]  al;
	} cmd_item_t;

	typedef struct {
		logic [2:0]  sts;
		logic [14:0] ap;
		logic [31:0] rv;
		logic [15:0] up;
		logic [15:0] fp;
	} reply_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [2:0] command = '0;
	logic [15:0] page = '0;
	logic [4:0] run_length = '0;
	logic [6:0] align_size = '0;
	logic out_valid, out_stall = 0;
	logic [2:0] status;
	logic [14:0] alloc_page;
	logic [31:0] ref_value;
	logic [15:0] used_pages, free_pages;

	bitmap_page_allocator_refcount_core uut (.*);

	always #6 clk = ~clk;

	// model state
	bit          m_used [NPG];
	logic [31:0] m_cnt [NPG];
	int          m_free;
	int          m_total, m_first;

	cmd_item_t pending[$];
	reply_t    expected_replies[$];
	int errors = 0;
	int in_idle_pct = 0, out_stall_pct = 0;
	bit hold_off = 0;

	function automatic reply_t predict_reply(cmd_item_t it);
		reply_t r;
		int tot, p, k;
		bit fit;
		logic [31:0] c;
		tot = (m_total < NPG) ? m_total : NPG;
		r.sts = STS_IGNORED; r.ap = '0; r.rv = '0;
		if (it.cmd == CMD_ALLOC) begin
			if (it.len == 0 || it.len > 16 || it.al == 0 || (it.al & (it.al - 1)) != 0 ||
					it.al > 64) begin
				r.sts = STS_BADARG;
			end else begin
				r.sts = STS_NOMEM;
				p = (m_first + it.al - 1) & ~(int'(it.al) - 1);
				for (; p + it.len <= tot; p += it.al) begin
					fit = 1;
					for (k = 0; k < it.len; k++)
						if (m_used[p+k]) fit = 0;
					if (fit) begin
						for (k = 0; k < it.len; k++) begin
							m_used[p+k] = 1; m_cnt[p+k] = 1;
							if (m_free > 0) m_free--;
						end
						r.sts = STS_OK; r.ap = p[14:0];
						break;
					end
				end
			end
		end else if (it.pg < tot) begin
			c = m_cnt[it.pg];
			case (it.cmd)
				CMD_FREE: if (m_used[it.pg]) begin
					if (c == PINNED) begin
						r.sts = STS_PINNED; r.rv = c;
					end else if (c > 1) begin
						m_cnt[it.pg] = c - 1; r.sts = STS_DEMOTED; r.rv = c - 1;
					end else begin
						m_cnt[it.pg] = 0; m_used[it.pg] = 0;
						if (m_free < 16'hFFFF) m_free++;
						r.sts = STS_OK;
					end
				end
				CMD_INCREF: begin
					if (c == PINNED) begin
						r.sts = STS_PINNED;
					end else begin
						c++; m_cnt[it.pg] = c;
						r.sts = (c == PINNED) ? STS_SATUR : STS_OK;
					end
					r.rv = c;
				end
				CMD_DECREF: if (c != 0) begin
					if (c == PINNED) begin
						r.sts = STS_PINNED; r.rv = c;
					end else begin
						c--; m_cnt[it.pg] = c;
						if (c == 0 && m_used[it.pg]) begin
							m_used[it.pg] = 0;
							if (m_free < 16'hFFFF) m_free++;
						end
						r.sts = STS_OK; r.rv = c;
					end
				end
				CMD_QUERY: begin
					r.sts = STS_OK; r.rv = c;
				end
				CMD_MARK_FREE: if (m_used[it.pg]) begin
					m_cnt[it.pg] = 0; m_used[it.pg] = 0;
					if (m_free < 16'hFFFF) m_free++;
					r.sts = STS_OK;
				end
				CMD_MARK_USED: if (!m_used[it.pg]) begin
					m_used[it.pg] = 1;
					if (m_free > 0) m_free--;
					r.sts = STS_OK;
				end
				default: ;
			endcase
		end
		r.up = (tot > m_free) ? 16'(tot - m_free) : 16'd0;
		r.fp = 16'(m_free);
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending.size() > 0 && !hold_off &&
						$urandom_range(99) >= in_idle_pct) begin
					cmd_item_t it;
					it = pending.pop_front();
					expected_replies.push_back(predict_reply(it));
					command <= it.cmd; page <= it.pg;
					run_length <= it.len; align_size <= it.al;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			reply_t e;
			if (expected_replies.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				errors++;
			end else begin
				e = expected_replies.pop_front();
				if (status !== e.sts) begin
					$error("status exp %0d got %0d", e.sts, status); errors++;
				end
				if (alloc_page !== e.ap) begin
					$error("alloc_page exp %0d got %0d", e.ap, alloc_page); errors++;
				end
				if (ref_value !== e.rv) begin
					$error("ref_value exp %0h got %0h", e.rv, ref_value); errors++;
				end
				if (used_pages !== e.up) begin
					$error("used_pages exp %0d got %0d", e.up, used_pages); errors++;
				end
				if (free_pages !== e.fp) begin
					$error("free_pages exp %0d got %0d", e.fp, free_pages); errors++;
				end
			end
		end
	end

	task automatic cfg_write(input logic sel, input int val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {sel, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (sel == REG_TOTAL) m_total = val & 16'hFFFF;
		else m_first = val & 16'hFFFF;
	endtask

	task automatic push_cmd(input logic [2:0] c, input int pg, input int len, input int al);
		cmd_item_t it;
		it.cmd = c; it.pg = pg; it.len = len; it.al = al;
		pending.push_back(it);
	endtask

	task automatic drain;
		wait (pending.size() == 0);
		@(posedge clk);
		@(posedge clk);
		while (expected_replies.size() > 0 || in_valid) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// random phase: mostly alloc/free/refcount traffic near the managed window
	task automatic random_items(input int n, input int win);
		int i, r, pg, al;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			pg = (r % 10 == 0) ? $urandom_range(65535) : $urandom_range(win - 1);
			al = 1 << $urandom_range(6);
			if (r < 5) push_cmd(CMD_ALLOC, 0, $urandom_range(31), $urandom_range(127));
			else if (r < 25) push_cmd(CMD_ALLOC, 0, $urandom_range(1, 8), al);
			else if (r < 35) push_cmd(CMD_FREE, pg, 0, 0);
			else if (r < 48) push_cmd(CMD_INCREF, pg, 0, 0);
			else if (r < 60) push_cmd(CMD_DECREF, pg, 0, 0);
			else if (r < 68) push_cmd(CMD_QUERY, pg, 0, 0);
			else if (r < 82) push_cmd(CMD_MARK_FREE, pg, 0, 0);
			else if (r < 92) push_cmd(CMD_MARK_USED, pg, 0, 0);
			else push_cmd(3'd7, pg, $urandom_range(31), $urandom_range(127));
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < NPG; i++) begin
			m_used[i] = 1; m_cnt[i] = '0;
		end
		m_free = 0; m_total = RST_TOTAL_PAGES; m_first = RST_FIRST_ALLOC;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// small window keeps scans short
		cfg_write(REG_TOTAL, 200);
		cfg_write(REG_FIRST, 3);
		for (i = 0; i < 200; i++) push_cmd(CMD_MARK_FREE, i, 0, 0);
		drain();
		// directed
		push_cmd(CMD_ALLOC, 0, 0, 1);
		push_cmd(CMD_ALLOC, 0, 17, 1);
		push_cmd(CMD_ALLOC, 0, 1, 0);
		push_cmd(CMD_ALLOC, 0, 1, 3);
		push_cmd(CMD_ALLOC, 0, 1, 127);
		push_cmd(CMD_ALLOC, 0, 16, 64);
		push_cmd(CMD_ALLOC, 0, 1, 1);
		push_cmd(CMD_ALLOC, 0, 16, 64);
		push_cmd(CMD_ALLOC, 0, 16, 64);
		push_cmd(CMD_INCREF, 3, 0, 0);
		push_cmd(CMD_FREE, 3, 0, 0);
		push_cmd(CMD_FREE, 3, 0, 0);
		push_cmd(CMD_FREE, 3, 0, 0);
		push_cmd(CMD_DECREF, 3, 0, 0);
		push_cmd(CMD_QUERY, 65535, 0, 0);
		push_cmd(CMD_MARK_USED, 199, 0, 0);
		push_cmd(CMD_MARK_USED, 199, 0, 0);
		push_cmd(CMD_MARK_FREE, 199, 0, 0);
		push_cmd(CMD_MARK_FREE, 200, 0, 0);
		push_cmd(3'd7, 5, 31, 127);
		push_cmd(CMD_DECREF, 64, 0, 0);
		drain();
		// counter saturation: preload a count near all ones by many increfs is
		// too slow, so pinning is reached only on narrow widths; checked as-is
		in_idle_pct = 0; out_stall_pct = 0;
		random_items(150, 220);
		drain();
		in_idle_pct = 76;
		random_items(150, 220);
		wait (pending.size() < 75);
		hold_off = 1;
		wait (expected_replies.size() == 0 && !in_valid);
		repeat (5) @(posedge clk);
		hold_off = 0;
		drain();
		cfg_write(REG_TOTAL, 1);
		cfg_write(REG_FIRST, 0);
		in_idle_pct = 0; out_stall_pct = 76;
		random_items(60, 4);
		drain();
		cfg_write(REG_TOTAL, 65535);
		cfg_write(REG_FIRST, 32768);
		in_idle_pct = 28; out_stall_pct = 28;
		random_items(60, 300);
		drain();
		cfg_write(REG_TOTAL, 120);
		cfg_write(REG_FIRST, 0);
		random_items(200, 130);
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#200ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_cfg.sv
rtl/bitmap_page_allocator_refcount_core.sv
dv/tb_bitmap_page_allocator_refcount_core.sv
